FILE: hw/rtl/chacha20_stream_cipher_unit_assert.svh
// Assertion macros used by the ChaCha20 stream cipher top level.
`ifndef CHACHA20_STREAM_CIPHER_UNIT_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_UNIT_ASSERT_SVH

// Check that a condition implies another one in the same cycle.
`define CC20_ASSERT_NOW(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Check that a condition implies another one in the next cycle.
`define CC20_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: hw/rtl/cc20_pkg.sv
// Shared types, constants and helpers of the ChaCha20 stream cipher.
package cc20_pkg;

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_KEY_0_1      = 3'd0;
   localparam logic [2:0] CSR_KEY_2_3      = 3'd1;
   localparam logic [2:0] CSR_KEY_4_5      = 3'd2;
   localparam logic [2:0] CSR_KEY_6_7      = 3'd3;
   localparam logic [2:0] CSR_NONCE_LOW    = 3'd4;
   localparam logic [2:0] CSR_NONCE_HIGH   = 3'd5;
   localparam logic [2:0] CSR_INIT_COUNTER = 3'd6;

   // "expand 32-byte k"
   localparam logic [31:0] SIGMA_0 = 32'h61707865;
   localparam logic [31:0] SIGMA_1 = 32'h3320646e;
   localparam logic [31:0] SIGMA_2 = 32'h79622d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b206574;

   localparam logic [4:0] LAST_ROUND = 5'd19;
   localparam logic [1:0] LAST_STEP  = 2'd3;

   typedef struct packed {
      logic [7:0][31:0] key;
      logic [2:0][31:0] nonce;
      logic [31:0]      initial_counter;
   } cc20_cfg_type;

   typedef struct packed {
      logic        start;
      logic [31:0] counter;
      logic [3:0]  ff_index;
   } cc20_core_ctl_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] ks_word;
   } cc20_core_sts_type;

   // Word index of one quarter-round operand (role 0..3 = a, b, c, d)
   function automatic logic [3:0] qr_index(input logic diag, input logic [1:0] lane,
                                           input logic [1:0] role);
      logic [1:0] ofs;
      ofs = diag ? (lane + role) : lane;
      return {role, ofs};
   endfunction

   // Initial block state word
   function automatic logic [31:0] init_word(input cc20_cfg_type cfg,
                                             input logic [31:0] counter,
                                             input logic [3:0] idx);
      logic [31:0] w;
      case (idx)
         4'd0:    w = SIGMA_0;
         4'd1:    w = SIGMA_1;
         4'd2:    w = SIGMA_2;
         4'd3:    w = SIGMA_3;
         4'd12:   w = counter;
         4'd13:   w = cfg.nonce[0];
         4'd14:   w = cfg.nonce[1];
         4'd15:   w = cfg.nonce[2];
         default: w = cfg.key[3'(idx - 4'd4)];
      endcase
      return w;
   endfunction

endpackage

FILE: hw/rtl/cc20_round_core.sv
// ChaCha20 round engine: working words, one quarter-round step per cycle on four lanes.
module cc20_round_core (
   input  logic                       clock,
   input  logic                       reset,
   input  cc20_pkg::cc20_cfg_type     cfg,
   input  cc20_pkg::cc20_core_ctl_type ctl,
   output cc20_pkg::cc20_core_sts_type sts
);
   import cc20_pkg::*;

   logic [15:0][31:0] w_ff, w_in;
   logic [31:0]       ctr_ff, ctr_in;
   logic [4:0]        round_ff, round_in;
   logic [1:0]        step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              last_step;

   assign last_step = (round_ff == LAST_ROUND) && (step_ff == LAST_STEP);

   // Load the initial state on start, else apply one step of the quarter-round to every lane
   always_comb begin
      logic [3:0]  ia, ib, ic, id;
      logic [31:0] x, y;
      w_in     = w_ff;
      ctr_in   = ctr_ff;
      round_in = round_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      if (ctl.start) begin
         for (int i = 0; i < 16; i++) begin
            w_in[i] = init_word(cfg, ctl.counter, 4'(i));
         end
         ctr_in   = ctl.counter;
         round_in = '0;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         for (int l = 0; l < 4; l++) begin
            ia = qr_index(round_ff[0], 2'(l), 2'd0);
            ib = qr_index(round_ff[0], 2'(l), 2'd1);
            ic = qr_index(round_ff[0], 2'(l), 2'd2);
            id = qr_index(round_ff[0], 2'(l), 2'd3);
            case (step_ff)
               2'd0: begin
                  x = w_ff[ia] + w_ff[ib];
                  y = w_ff[id] ^ x;
                  w_in[ia] = x;
                  w_in[id] = {y[15:0], y[31:16]};
               end
               2'd1: begin
                  x = w_ff[ic] + w_ff[id];
                  y = w_ff[ib] ^ x;
                  w_in[ic] = x;
                  w_in[ib] = {y[19:0], y[31:20]};
               end
               2'd2: begin
                  x = w_ff[ia] + w_ff[ib];
                  y = w_ff[id] ^ x;
                  w_in[ia] = x;
                  w_in[id] = {y[23:0], y[31:24]};
               end
               default: begin
                  x = w_ff[ic] + w_ff[id];
                  y = w_ff[ib] ^ x;
                  w_in[ic] = x;
                  w_in[ib] = {y[24:0], y[31:25]};
               end
            endcase
         end
         step_in = step_ff + 2'd1;
         if (step_ff == LAST_STEP) begin
            round_in = round_ff + 5'd1;
         end
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= '0;
         step_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         round_ff <= round_in;
         step_ff  <= step_in;
      end
      w_ff   <= w_in;
      ctr_ff <= ctr_in;
   end

   // Feed-forward add for the word the fill sweep selects
   assign sts.busy    = busy_ff;
   assign sts.done    = busy_ff && last_step;
   assign sts.ks_word = w_ff[ctl.ff_index] + init_word(cfg, ctr_ff, ctl.ff_index);

endmodule

FILE: hw/rtl/chacha20_stream_cipher_unit.sv
// Top level of the ChaCha20 stream cipher: control, keystream memory, output register.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | data_word, valid_bytes, first_word
//   rsp     | out       | rsp_valid/stall    | out_word, out_valid_bytes
//   csr     | in        | csr_write_en       | csr_index, csr_data
//
// A word inside a block passes through accept, keystream memory read and output load.
// A word at block start adds the rounds (one quarter-round step per cycle)
// and a sweep that writes the keystream memory.
// One transaction is in work at a time.
// Reset is synchronous; the keystream memory needs no clearing.
// A new transaction is taken while a result still waits under rsp_stall.
module chacha20_stream_cipher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_first_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_word,
   output logic [2:0]  rsp_out_valid_bytes,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import cc20_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_GEN  = 5'b00010,
      ST_FILL = 5'b00100,
      ST_READ = 5'b01000,
      ST_WAIT = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   cc20_cfg_type      cfg_ff, cfg_in;
   logic [3:0]        pos_ff, pos_in;
   logic [31:0]       cnt_ff, cnt_in;
   logic [3:0]        fill_ff, fill_in;
   logic [31:0]       data_ff, data_in;
   logic [2:0]        nb_ff, nb_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_word_ff, rsp_word_in;
   logic [2:0]        rsp_nb_ff, rsp_nb_in;
   logic [31:0]       ks_mem [16];
   logic [31:0]       rd_data_ff;
   logic              rd_en, wr_en;
   logic [3:0]        rd_addr;
   logic              req_accept;
   logic [3:0]        pos_eff;
   logic [31:0]       cnt_eff, mask;
   cc20_core_ctl_type core_ctl;
   cc20_core_sts_type core_sts;

   cc20_round_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .ctl   (core_ctl),
      .sts   (core_sts)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign pos_eff    = req_first_word ? 4'd0 : pos_ff;
   assign cnt_eff    = req_first_word ? cfg_ff.initial_counter : cnt_ff;

   // Take configuration writes; drop indexes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_KEY_0_1:      cfg_in.key[1:0] = csr_data;
            CSR_KEY_2_3:      cfg_in.key[3:2] = csr_data;
            CSR_KEY_4_5:      cfg_in.key[5:4] = csr_data;
            CSR_KEY_6_7:      cfg_in.key[7:6] = csr_data;
            CSR_NONCE_LOW:    cfg_in.nonce[1:0] = csr_data;
            CSR_NONCE_HIGH:   cfg_in.nonce[2] = csr_data[31:0];
            CSR_INIT_COUNTER: cfg_in.initial_counter = csr_data[31:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Byte mask of a short word
   always_comb begin
      case (nb_ff)
         3'd0:    mask = 32'h0000_0000;
         3'd1:    mask = 32'h0000_00ff;
         3'd2:    mask = 32'h0000_ffff;
         3'd3:    mask = 32'h00ff_ffff;
         default: mask = 32'hffff_ffff;
      endcase
   end

   // Sequence one transaction: generate block if needed, read keystream, load output
   always_comb begin
      state_in          = state_ff;
      pos_in            = pos_ff;
      cnt_in            = cnt_ff;
      fill_in           = fill_ff;
      data_in           = data_ff;
      nb_in             = nb_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_word_in       = rsp_word_ff;
      rsp_nb_in         = rsp_nb_ff;
      rd_en             = 1'b0;
      rd_addr           = pos_ff;
      wr_en             = 1'b0;
      core_ctl.start    = 1'b0;
      core_ctl.counter  = cnt_eff;
      core_ctl.ff_index = fill_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               data_in = req_data_word;
               nb_in   = req_valid_bytes;
               pos_in  = pos_eff;
               cnt_in  = cnt_eff;
               if (pos_eff == 4'd0) begin
                  core_ctl.start = 1'b1;
                  cnt_in         = cnt_eff + 32'd1;
                  state_in       = ST_GEN;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = pos_eff;
                  state_in = ST_READ;
               end
            end
         end
         ST_GEN: begin
            if (core_sts.done) begin
               fill_in  = 4'd0;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            fill_in = fill_ff + 4'd1;
            if (fill_ff == 4'd15) begin
               rd_en    = 1'b1;
               rd_addr  = pos_ff;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = (data_ff ^ rd_data_ff) & mask;
               rsp_nb_in    = nb_ff;
               pos_in       = pos_ff + 4'd1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Keystream memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ks_mem[fill_ff] <= core_sts.ks_word;
      end
      if (rd_en) begin
         rd_data_ff <= ks_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      data_ff     <= data_in;
      nb_ff       <= nb_in;
      rsp_word_ff <= rsp_word_in;
      rsp_nb_ff   <= rsp_nb_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_word        = rsp_word_ff;
   assign rsp_out_valid_bytes = rsp_nb_ff;

`include "chacha20_stream_cipher_unit_assert.svh"

   `CC20_ASSERT_NEXT(a_done_fill, core_sts.done, state_ff == ST_FILL, "done without fill")
   `CC20_ASSERT_NOW(a_start_idle, core_ctl.start, !core_sts.busy, "start while busy")
   `CC20_ASSERT_NEXT(a_read_wait, state_ff == ST_READ, state_ff == ST_WAIT, "read not waited")
   `CC20_ASSERT_NOW(a_gen_busy, state_ff == ST_GEN, core_sts.busy, "gen with idle core")

endmodule
